>>> src/multi_slot_soft_timer_table_defines.svh
// ----------------------------------------------------------------------------
// Timer table assertion macros
// Concurrent check wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_SOFT_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_SOFT_TIMER_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define MSTT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mstt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MSTT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mstt: next-cycle check failed");

`else

`define MSTT_ASSERT_SAME(label, ante, cons)
`define MSTT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/mstt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Sizes, command and status codes, and transaction payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package mstt_pkg;

  // Table geometry
  localparam int SLOTS     = 16;
  localparam int TICK_BITS = 32;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Shared adder: 32-bit operands plus a borrow bit
  localparam int ALU_W  = 33;
  localparam int LATE_W = 31;

  // Command codes
  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_SCAN   = 2'd2
  } kind_t;

  // Result codes
  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED     = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_t;

  // Command transaction
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         handle;
    logic signed [31:0] delay_ms;
    logic [30:0]        repeat_ms;
    logic [30:0]        expire_ms;
    logic [31:0]        now_tick;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    status_t            status;
    logic [3:0]         slot;
    logic [7:0]         task_handle;
    logic               finished;
    logic [LATE_W-1:0]  lateness_ms;
    logic               last;
  } rsp_t;

  // Shared adder request
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

endpackage

`default_nettype wire

>>> src/mstt_alu.sv
// ----------------------------------------------------------------------------
// Timer table shared adder
// One 33-bit add/subtract unit; bit 32 of a difference is the borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module mstt_alu (
  input  wire mstt_pkg::alu_req_t      req,
  output logic [mstt_pkg::ALU_W-1:0]  res
);

  // Add or subtract, selected by the sequencer
  always_comb begin
    if (req.sub) begin
      res = req.a - req.b;
    end else begin
      res = req.a + req.b;
    end
  end

endmodule

`default_nettype wire

>>> src/multi_slot_soft_timer_table.sv
// ----------------------------------------------------------------------------
// Multi-slot soft timer table
// Add, remove and scan commands over a table of one-shot/periodic timers.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every result is
// shown on rsp for exactly one cycle with rsp_valid high and cannot be held
// off, so the receiver must take it then; rsp.last marks the final result of
// a command, and an unused kind code gives no result. Add, and add or remove
// with a zero handle, are answered straight from idle (busy stays low). Remove
// walks the table, matching each live slot's handle, with a closing step if
// none matches. Scan walks the table with one shared 33-bit adder used five
// times per due slot: free slots are skipped, live slots get a due test, and
// due slots a lifetime test and write-back; a closing step ends the walk. The
// slot record store is a single-port-write, registered-read memory.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_slot_soft_timer_table_defines.svh"

module multi_slot_soft_timer_table (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire mstt_pkg::cmd_t cmd,
  output logic                busy,
  output mstt_pkg::rsp_t      rsp,
  output logic                rsp_valid
);

  localparam int SLOTS = mstt_pkg::SLOTS;
  localparam int TB    = mstt_pkg::TICK_BITS;
  localparam int IW    = mstt_pkg::IDX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_CHK, S_CMP, S_SINCE, S_LIFE, S_WB, S_END
  } state_t;

  // One slot record
  typedef struct packed {
    logic [7:0]    handle;
    logic [TB-1:0] start;
    logic [TB-1:0] origin;
    logic [31:0]   trigger;
    logic [30:0]   rep;
    logic [30:0]   lifetime;
  } rec_t;

  state_t                    state;
  logic [IW-1:0]             idx;
  logic [SLOTS-1:0]          live;
  mstt_pkg::cmd_t            cmd_q;
  rec_t                      mem [SLOTS];
  rec_t                      rd_rec;
  logic [TB-1:0]             elapsed;
  logic [TB-1:0]             since;
  logic [31:0]               late;
  logic                      expired;
  mstt_pkg::rsp_t            pend;
  logic                      pend_valid;

  logic                      free_found;
  logic [IW-1:0]             free_idx;
  logic                      at_end;
  logic                      fire;
  logic                      fin;
  mstt_pkg::alu_req_t        alu_req;
  logic [mstt_pkg::ALU_W-1:0] alu_res;
  logic                      mem_we;
  logic [IW-1:0]             mem_waddr;
  rec_t                      mem_wdata;

  function automatic mstt_pkg::rsp_t mk_rsp(input mstt_pkg::status_t st,
                                            input logic [3:0] sl,
                                            input logic [7:0] h,
                                            input logic f,
                                            input logic [30:0] lt,
                                            input logic lst);
    mstt_pkg::rsp_t r;
    r.status      = st;
    r.slot        = sl;
    r.task_handle = h;
    r.finished    = f;
    r.lateness_ms = lt;
    r.last        = lst;
    return r;
  endfunction

  assign busy   = (state != S_IDLE);
  assign at_end = (idx == IW'(SLOTS - 1));

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // Shared adder operand select
  always_comb begin
    alu_req = '0;
    case (state)
      S_CHK: begin
        alu_req.a   = mstt_pkg::ALU_W'(cmd_q.now_tick[TB-1:0]);
        alu_req.b   = mstt_pkg::ALU_W'(rd_rec.start);
        alu_req.sub = 1'b1;
      end
      S_CMP: begin
        alu_req.a   = mstt_pkg::ALU_W'(elapsed);
        alu_req.b   = {1'b0, rd_rec.trigger};
        alu_req.sub = 1'b1;
      end
      S_SINCE: begin
        alu_req.a   = mstt_pkg::ALU_W'(cmd_q.now_tick[TB-1:0]);
        alu_req.b   = mstt_pkg::ALU_W'(rd_rec.origin);
        alu_req.sub = 1'b1;
      end
      S_LIFE: begin
        alu_req.a   = {2'b00, rd_rec.lifetime};
        alu_req.b   = mstt_pkg::ALU_W'(since);
        alu_req.sub = 1'b1;
      end
      S_WB: begin
        alu_req.a   = mstt_pkg::ALU_W'(rd_rec.start);
        alu_req.b   = {1'b0, rd_rec.trigger};
        alu_req.sub = 1'b0;
      end
      default: ;
    endcase
  end

  mstt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Due when elapsed - trigger is positive; freed if one-shot or expired
  assign fire = !alu_res[32] && (alu_res[31:0] != 32'd0);
  assign fin  = (rd_rec.rep == 31'd0) || expired;

  // Record store write: new timer on add, advanced timer on fire
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = rd_rec;
    if (state == S_IDLE && start && cmd.kind == mstt_pkg::KIND_ADD &&
        cmd.handle != 8'd0 && free_found) begin
      mem_we             = 1'b1;
      mem_waddr          = free_idx;
      mem_wdata.handle   = cmd.handle;
      mem_wdata.start    = cmd.now_tick[TB-1:0];
      mem_wdata.origin   = cmd.now_tick[TB-1:0];
      mem_wdata.trigger  = cmd.delay_ms[31] ? {1'b0, cmd.repeat_ms}
                                            : $unsigned(cmd.delay_ms);
      mem_wdata.rep      = cmd.repeat_ms;
      mem_wdata.lifetime = cmd.expire_ms;
    end else if (state == S_WB) begin
      mem_we          = 1'b1;
      mem_wdata.start = alu_res[TB-1:0];
      if (rd_rec.rep != 31'd0) begin
        mem_wdata.trigger = {1'b0, rd_rec.rep};
      end
    end
  end

  // Record store, registered read at the walk index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_rec <= mem[idx];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      live       <= '0;
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          // Add and zero-handle remove answer right away
          rsp_valid <= start && (cmd.kind == mstt_pkg::KIND_ADD ||
                                 (cmd.kind == mstt_pkg::KIND_REMOVE &&
                                  cmd.handle == 8'd0));
          if (start) begin
            cmd_q <= cmd;
            idx   <= '0;
            case (cmd.kind)
              mstt_pkg::KIND_ADD: begin
                if (cmd.handle == 8'd0) begin
                  rsp <= mk_rsp(mstt_pkg::ST_NOT_FOUND, 4'd0, 8'd0, 1'b0, 31'd0, 1'b1);
                end else if (free_found) begin
                  live[free_idx] <= 1'b1;
                  rsp <= mk_rsp(mstt_pkg::ST_ADDED, 4'(free_idx), cmd.handle,
                                1'b0, 31'd0, 1'b1);
                end else begin
                  rsp <= mk_rsp(mstt_pkg::ST_FULL, 4'd0, 8'd0, 1'b0, 31'd0, 1'b1);
                end
              end
              mstt_pkg::KIND_REMOVE: begin
                if (cmd.handle == 8'd0) begin
                  rsp <= mk_rsp(mstt_pkg::ST_NOT_FOUND, 4'd0, 8'd0, 1'b0, 31'd0, 1'b1);
                end else begin
                  state <= S_RD;
                end
              end
              mstt_pkg::KIND_SCAN: begin
                state <= S_RD;
              end
              default: ;
            endcase
          end
        end

        // Skip free slots; read the record of a live one
        S_RD: begin
          rsp_valid <= 1'b0;
          if (live[idx]) begin
            state <= S_CHK;
          end else if (at_end) begin
            state <= S_END;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        // Remove: handle match. Scan: elapsed time
        S_CHK: begin
          rsp_valid <= (cmd_q.kind == mstt_pkg::KIND_REMOVE) &&
                       (rd_rec.handle == cmd_q.handle);
          if (cmd_q.kind == mstt_pkg::KIND_REMOVE) begin
            if (rd_rec.handle == cmd_q.handle) begin
              live[idx] <= 1'b0;
              rsp <= mk_rsp(mstt_pkg::ST_REMOVED, 4'(idx), cmd_q.handle,
                            1'b0, 31'd0, 1'b1);
              state <= S_IDLE;
            end else if (at_end) begin
              state <= S_END;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_RD;
            end
          end else begin
            elapsed <= alu_res[TB-1:0];
            state   <= S_CMP;
          end
        end

        // Due test
        S_CMP: begin
          rsp_valid <= 1'b0;
          if (fire) begin
            late  <= alu_res[31:0];
            state <= S_SINCE;
          end else if (at_end) begin
            state <= S_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end

        // Time since the add
        S_SINCE: begin
          rsp_valid <= 1'b0;
          since     <= alu_res[TB-1:0];
          state     <= S_LIFE;
        end

        // Lifetime test: borrow means since exceeds lifetime
        S_LIFE: begin
          rsp_valid <= 1'b0;
          expired   <= (rd_rec.lifetime != 31'd0) && alu_res[32];
          state     <= S_WB;
        end

        // Fire: release the held result, hold this one until we know if last
        S_WB: begin
          rsp_valid <= pend_valid;
          if (pend_valid) begin
            rsp <= pend;
          end
          pend <= mk_rsp(mstt_pkg::ST_FIRED, 4'(idx), rd_rec.handle, fin,
                         late[31] ? {mstt_pkg::LATE_W{1'b1}} : late[30:0], 1'b0);
          pend_valid <= 1'b1;
          if (fin) begin
            live[idx] <= 1'b0;
          end
          if (at_end) begin
            state <= S_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end

        // Closing result of the walk
        S_END: begin
          rsp_valid <= 1'b1;
          if (cmd_q.kind == mstt_pkg::KIND_REMOVE) begin
            rsp <= mk_rsp(mstt_pkg::ST_NOT_FOUND, 4'd0, 8'd0, 1'b0, 31'd0, 1'b1);
          end else if (pend_valid) begin
            rsp <= mk_rsp(pend.status, pend.slot, pend.task_handle, pend.finished,
                          pend.lateness_ms, 1'b1);
          end else begin
            rsp <= mk_rsp(mstt_pkg::ST_NONE_DUE, 4'd0, 8'd0, 1'b0, 31'd0, 1'b1);
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end

        default: begin
          rsp_valid <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  `MSTT_ASSERT_SAME(a_idle_no_pend, !busy, !pend_valid)
  `MSTT_ASSERT_SAME(a_idle_rsp_last, rsp_valid && !busy, rsp.last)
  `MSTT_ASSERT_SAME(a_mid_rsp_busy, rsp_valid && !rsp.last, busy)
  `MSTT_ASSERT_NEXT(a_scan_starts, start && !busy && cmd.kind == mstt_pkg::KIND_SCAN, busy)

endmodule

`default_nettype wire
